### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the linked list checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication, off during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

### hw/rtl/alli_pkg.sv
// ----------------------------------------------------------------------------
// alli_pkg
// Types and constants shared by the array linked list insert core.
// ----------------------------------------------------------------------------
package alli_pkg;

    localparam int DATA_W   = 32;
    localparam int POS_W    = 9;
    localparam int SLOT_W   = 8;
    localparam int STATUS_W = 2;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_READ   = 1'b1;

    typedef struct packed {
        logic value_we;
        logic next_we;
    } store_wen_t;

endpackage

### hw/rtl/alli_store.sv
// ----------------------------------------------------------------------------
// alli_store
// Slot store: value memory and next-pointer memory, one write and one
// registered read port each.
// ----------------------------------------------------------------------------
module alli_store #(
    parameter int CAPACITY = 256,
    parameter int AW       = 8,
    parameter int PW       = 9
) (
    input  logic                        clk,
    input  alli_pkg::store_wen_t        wen,
    input  logic [AW-1:0]               value_waddr,
    input  logic [alli_pkg::DATA_W-1:0] value_wdata,
    input  logic [AW-1:0]               value_raddr,
    output logic [alli_pkg::DATA_W-1:0] value_rdata,
    input  logic [AW-1:0]               next_waddr,
    input  logic [PW-1:0]               next_wdata,
    input  logic [AW-1:0]               next_raddr,
    output logic [PW-1:0]               next_rdata
);
    import alli_pkg::*;

    logic [DATA_W-1:0] value_mem [CAPACITY];
    logic [PW-1:0]     next_mem  [CAPACITY];

    always_ff @(posedge clk)
    begin
        if (wen.value_we)
        begin
            value_mem[value_waddr] <= value_wdata;
        end
        value_rdata <= value_mem[value_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (wen.next_we)
        begin
            next_mem[next_waddr] <= next_wdata;
        end
        next_rdata <= next_mem[next_raddr];
    end

endmodule

### hw/rtl/array_linked_list_insert_core.sv
// ----------------------------------------------------------------------------
// array_linked_list_insert_core
// Singly linked list in a fixed slot store with insert and read commands.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low: kind, value, position.
// kind 0 inserts value into the next free slot and links it in at position
// (clamped to the element count); kind 1 reads the element at position.
// Each word yields one result word, marked by done for one cycle, on
// status, data_out, slot and length; the receiver cannot stall it.
// Refused words (store full, read out of range) and inserts at the head or
// into an empty list answer in the cycle after acceptance, busy stays low.
// Other words walk the next-pointer chain through the single read port of
// the pointer memory, each link followed in a walk state and a step state;
// a read then passes a value wait state, an insert a link wait state and a
// link state. Busy is high throughout the walk, and done comes in the first
// cycle with busy low again.
// Reset empties the list at once (head at end marker, count zero); the slot
// memories need no clearing pass.
// ----------------------------------------------------------------------------
module array_linked_list_insert_core #(
    parameter int CAPACITY = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          kind,
    input  logic [alli_pkg::DATA_W-1:0]   value,
    input  logic [alli_pkg::POS_W-1:0]    position,
    output logic                          done,
    output logic [alli_pkg::STATUS_W-1:0] status,
    output logic [alli_pkg::DATA_W-1:0]   data_out,
    output logic [alli_pkg::SLOT_W-1:0]   slot,
    output logic [alli_pkg::POS_W-1:0]    length
);
    import alli_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int PW = $clog2(CAPACITY + 1);
    localparam int CW = (PW > POS_W) ? PW : POS_W;
    localparam logic [PW-1:0] END_MARK = PW'(CAPACITY);
    localparam logic [CW-1:0] FULL_CNT = CW'(CAPACITY);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_WALK  = 3'd1;
    localparam logic [2:0] S_STEP  = 3'd2;
    localparam logic [2:0] S_VWAIT = 3'd3;
    localparam logic [2:0] S_LWAIT = 3'd4;
    localparam logic [2:0] S_LINK  = 3'd5;

    logic [2:0]          state_reg, state_next;
    logic                kind_reg, kind_next;
    logic [DATA_W-1:0]   value_reg, value_next;
    logic [PW-1:0]       at_reg, at_next;
    logic [POS_W-1:0]    steps_reg, steps_next;
    logic [PW-1:0]       head_reg, head_next;
    logic [PW-1:0]       count_reg, count_next;
    logic                done_reg, done_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [DATA_W-1:0]   data_reg, data_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic [POS_W-1:0]    length_reg, length_next;

    logic              accept;
    logic [CW-1:0]     pos_ext;
    logic [CW-1:0]     count_ext;
    logic [CW-1:0]     clamp_ext;
    logic [CW-1:0]     prev_ext;
    logic [PW-1:0]     count_inc;
    logic [CW-1:0]     count_inc_ext;
    logic [CW-1:0]     at_ext;
    logic [AW-1:0]     fresh_idx;

    store_wen_t        wen;
    logic [AW-1:0]     value_waddr;
    logic [DATA_W-1:0] value_wdata;
    logic [AW-1:0]     value_raddr;
    logic [DATA_W-1:0] value_rdata;
    logic [AW-1:0]     next_waddr;
    logic [PW-1:0]     next_wdata;
    logic [AW-1:0]     next_raddr;
    logic [PW-1:0]     next_rdata;

    assign busy     = (state_reg != S_IDLE);
    assign accept   = start && !busy;
    assign done     = done_reg;
    assign status   = status_reg;
    assign data_out = data_reg;
    assign slot     = slot_reg;
    assign length   = length_reg;

    assign pos_ext       = CW'(position);
    assign count_ext     = CW'(count_reg);
    assign clamp_ext     = (pos_ext < count_ext) ? pos_ext : count_ext;
    assign prev_ext      = clamp_ext - CW'(1);
    assign count_inc     = count_reg + PW'(1);
    assign count_inc_ext = CW'(count_inc);
    assign at_ext        = CW'(at_reg);
    assign fresh_idx     = count_reg[AW-1:0];

    alli_store #(
        .CAPACITY (CAPACITY),
        .AW       (AW),
        .PW       (PW)
    ) u_store (
        .clk         (clk),
        .wen         (wen),
        .value_waddr (value_waddr),
        .value_wdata (value_wdata),
        .value_raddr (value_raddr),
        .value_rdata (value_rdata),
        .next_waddr  (next_waddr),
        .next_wdata  (next_wdata),
        .next_raddr  (next_raddr),
        .next_rdata  (next_rdata)
    );

    always_comb
    begin
        state_next  = state_reg;
        kind_next   = kind_reg;
        value_next  = value_reg;
        at_next     = at_reg;
        steps_next  = steps_reg;
        head_next   = head_reg;
        count_next  = count_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        data_next   = data_reg;
        slot_next   = slot_reg;
        length_next = length_reg;

        wen         = '0;
        value_waddr = fresh_idx;
        value_wdata = value_reg;
        value_raddr = at_reg[AW-1:0];
        next_waddr  = fresh_idx;
        next_wdata  = END_MARK;
        next_raddr  = at_reg[AW-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    kind_next  = kind;
                    value_next = value;
                    if (kind == KIND_READ)
                    begin
                        if (pos_ext >= count_ext)
                        begin
                            done_next   = 1'b1;
                            status_next = ST_RANGE;
                            data_next   = '0;
                            slot_next   = '0;
                            length_next = count_ext[POS_W-1:0];
                        end
                        else
                        begin
                            at_next    = head_reg;
                            steps_next = position;
                            state_next = S_WALK;
                        end
                    end
                    else if (count_ext >= FULL_CNT)
                    begin
                        done_next   = 1'b1;
                        status_next = ST_FULL;
                        data_next   = '0;
                        slot_next   = '0;
                        length_next = count_ext[POS_W-1:0];
                    end
                    else if ((count_reg == '0) || (position == '0))
                    begin
                        wen.value_we = 1'b1;
                        value_wdata  = value;
                        wen.next_we  = 1'b1;
                        next_wdata   = (count_reg == '0) ? END_MARK : head_reg;
                        head_next    = count_reg;
                        count_next   = count_inc;
                        done_next    = 1'b1;
                        status_next  = ST_OK;
                        data_next    = '0;
                        slot_next    = count_ext[SLOT_W-1:0];
                        length_next  = count_inc_ext[POS_W-1:0];
                    end
                    else
                    begin
                        at_next    = head_reg;
                        steps_next = prev_ext[POS_W-1:0];
                        state_next = S_WALK;
                    end
                end
            end

            S_WALK:
            begin
                if (steps_reg == '0)
                begin
                    state_next = (kind_reg == KIND_READ) ? S_VWAIT : S_LWAIT;
                end
                else
                begin
                    state_next = S_STEP;
                end
            end

            S_STEP:
            begin
                at_next    = next_rdata;
                steps_next = steps_reg - POS_W'(1);
                state_next = S_WALK;
            end

            S_VWAIT:
            begin
                done_next   = 1'b1;
                status_next = ST_OK;
                data_next   = value_rdata;
                slot_next   = at_ext[SLOT_W-1:0];
                length_next = count_ext[POS_W-1:0];
                state_next  = S_IDLE;
            end

            S_LWAIT:
            begin
                wen.value_we = 1'b1;
                wen.next_we  = 1'b1;
                next_wdata   = next_rdata;
                state_next   = S_LINK;
            end

            S_LINK:
            begin
                wen.next_we = 1'b1;
                next_waddr  = at_reg[AW-1:0];
                next_wdata  = count_reg;
                count_next  = count_inc;
                done_next   = 1'b1;
                status_next = ST_OK;
                data_next   = '0;
                slot_next   = count_ext[SLOT_W-1:0];
                length_next = count_inc_ext[POS_W-1:0];
                state_next  = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg  <= END_MARK;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        value_reg  <= value_next;
        at_reg     <= at_next;
        steps_reg  <= steps_next;
        status_reg <= status_next;
        data_reg   <= data_next;
        slot_reg   <= slot_next;
        length_reg <= length_next;
    end

endmodule

### hw/rtl/alli_checker.sv
// ----------------------------------------------------------------------------
// alli_port_checker
// Port-level checks on the linked list core, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module alli_port_checker #(
    parameter int CAPACITY = 256
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          done,
    input logic [alli_pkg::STATUS_W-1:0] status,
    input logic [alli_pkg::DATA_W-1:0]   data_out,
    input logic [alli_pkg::SLOT_W-1:0]   slot,
    input logic [alli_pkg::POS_W-1:0]    length
);
    import alli_pkg::*;

    localparam logic [POS_W-1:0] FULL_LEN = POS_W'(CAPACITY);

    logic accepted;
    logic err_word;
    logic full_word;

    assign accepted  = start && !busy;
    assign err_word  = done && (status != ST_OK);
    assign full_word = done && (status == ST_FULL);

    `ASSERT_NEXT(a_word_answered, clk, rst_n, accepted, done || busy)
    `ASSERT_IMPLY(a_done_when_idle, clk, rst_n, done, !busy)
    `ASSERT_IMPLY(a_error_zeroed, clk, rst_n, err_word, (data_out == '0) && (slot == '0))
    `ASSERT_IMPLY(a_full_length, clk, rst_n, full_word, length == FULL_LEN)

endmodule

bind array_linked_list_insert_core alli_port_checker #(
    .CAPACITY (CAPACITY)
) u_alli_port_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .done     (done),
    .status   (status),
    .data_out (data_out),
    .slot     (slot),
    .length   (length)
);

### tb/sv/alli_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// alli_checker
// Watches the command and result words of the linked list core. Keeps its
// own copy of the slot store, head and count, works out the result of every
// accepted word, and compares each result word field by field in order.
// ----------------------------------------------------------------------------
module alli_checker #(
    parameter int CAPACITY = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  logic                          kind,
    input  logic [alli_pkg::DATA_W-1:0]   value,
    input  logic [alli_pkg::POS_W-1:0]    position,
    input  logic                          done,
    input  logic [alli_pkg::STATUS_W-1:0] status,
    input  logic [alli_pkg::DATA_W-1:0]   data_out,
    input  logic [alli_pkg::SLOT_W-1:0]   slot,
    input  logic [alli_pkg::POS_W-1:0]    length,
    output int                            mismatches,
    output int                            pending,
    output int                            inserts_ok,
    output int                            inserts_full,
    output int                            reads_ok,
    output int                            reads_range
);

    import alli_pkg::*;

    localparam logic [POS_W-1:0] END_MARK = POS_W'(CAPACITY);

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [DATA_W-1:0]   data;
        logic [SLOT_W-1:0]   slot;
        logic [POS_W-1:0]    length;
    } list_result_t;

    logic [DATA_W-1:0] slot_value [CAPACITY];
    logic [POS_W-1:0]  slot_link  [CAPACITY];
    logic [POS_W-1:0]  head_at;
    logic [POS_W-1:0]  elem_count;
    list_result_t      result_q [$];

    initial
    begin
        head_at      = END_MARK;
        elem_count   = '0;
        mismatches   = 0;
        pending      = 0;
        inserts_ok   = 0;
        inserts_full = 0;
        reads_ok     = 0;
        reads_range  = 0;
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (mismatches < 40)
            $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
        mismatches++;
    endtask

    function automatic logic [POS_W-1:0] chase_links(input logic [POS_W-1:0] steps);
        logic [POS_W-1:0] at;
        at = head_at;
        for (int i = 0; i < steps; i++)
        begin
            if (at >= CAPACITY)
                break;
            at = slot_link[at];
        end
        return at;
    endfunction

    function automatic list_result_t apply_word(input logic k, input logic [DATA_W-1:0] v,
                                                input logic [POS_W-1:0] pos);
        list_result_t     r;
        logic [POS_W-1:0] at;
        logic [POS_W-1:0] fresh;
        logic [POS_W-1:0] prev;
        logic [POS_W-1:0] clamped;
        r        = '0;
        r.status = ST_OK;
        r.length = elem_count;
        if (k == KIND_READ)
        begin
            if (pos >= elem_count)
                r.status = ST_RANGE;
            else
            begin
                at = chase_links(pos);
                if (at >= CAPACITY)
                    r.status = ST_RANGE;
                else
                begin
                    r.data = slot_value[at];
                    r.slot = at[SLOT_W-1:0];
                end
            end
        end
        else if (elem_count >= CAPACITY)
            r.status = ST_FULL;
        else
        begin
            fresh = elem_count;
            slot_value[fresh] = v;
            if (elem_count == 0)
            begin
                slot_link[fresh] = END_MARK;
                head_at = fresh;
            end
            else if (pos == 0)
            begin
                slot_link[fresh] = head_at;
                head_at = fresh;
            end
            else
            begin
                clamped = (pos < elem_count) ? pos : elem_count;
                prev = chase_links(clamped - 1'b1);
                if (prev < CAPACITY)
                begin
                    slot_link[fresh] = slot_link[prev];
                    slot_link[prev] = fresh;
                end
                else
                    slot_link[fresh] = END_MARK;
            end
            elem_count = elem_count + 1'b1;
            r.slot   = fresh[SLOT_W-1:0];
            r.length = elem_count;
        end
        return r;
    endfunction

    always @(posedge clk)
    begin : watch
        list_result_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (result_q.size() == 0)
                    report_mismatch("result word with nothing pending, status", status, 0);
                else
                begin
                    want = result_q.pop_front();
                    if (status !== want.status)
                        report_mismatch("status", status, want.status);
                    if (data_out !== want.data)
                        report_mismatch("data_out", data_out, want.data);
                    if (slot !== want.slot)
                        report_mismatch("slot", slot, want.slot);
                    if (length !== want.length)
                        report_mismatch("length", length, want.length);
                end
            end
            if (start && !busy)
            begin
                want = apply_word(kind, value, position);
                result_q.push_back(want);
                if (kind == KIND_INSERT)
                begin
                    if (want.status == ST_FULL)
                        inserts_full++;
                    else
                        inserts_ok++;
                end
                else if (want.status == ST_RANGE)
                    reads_range++;
                else
                    reads_ok++;
            end
            pending = result_q.size();
        end
    end

endmodule

### tb/sv/tb_array_linked_list_insert_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_array_linked_list_insert_core
// Drives insert and read words into the linked list core: a directed pass
// over empty list, head, append and middle inserts and out-of-range reads,
// then random words that fill the store past full, under several sender
// idling phases. The checker beside the core predicts and compares.
// ----------------------------------------------------------------------------
module tb_array_linked_list_insert_core;

    import alli_pkg::*;

    localparam int CAPACITY     = 256;
    localparam int ITEMS        = 1350;
    localparam int PHASE_ITEMS  = 150;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 600;

    typedef enum int {IDLE_NONE, IDLE_HEAVY, IDLE_LIGHT} idle_mode_t;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic                kind;
    logic [DATA_W-1:0]   value;
    logic [POS_W-1:0]    position;
    logic                done;
    logic [STATUS_W-1:0] status;
    logic [DATA_W-1:0]   data_out;
    logic [SLOT_W-1:0]   slot;
    logic [POS_W-1:0]    length;

    int         mismatches;
    int         pending;
    int         inserts_ok;
    int         inserts_full;
    int         reads_ok;
    int         reads_range;
    int         fill;
    int         stall_cycles;
    idle_mode_t idle_mode;

    array_linked_list_insert_core #(
        .CAPACITY (CAPACITY)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .kind     (kind),
        .value    (value),
        .position (position),
        .done     (done),
        .status   (status),
        .data_out (data_out),
        .slot     (slot),
        .length   (length)
    );

    alli_checker #(
        .CAPACITY (CAPACITY)
    ) u_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .kind         (kind),
        .value        (value),
        .position     (position),
        .done         (done),
        .status       (status),
        .data_out     (data_out),
        .slot         (slot),
        .length       (length),
        .mismatches   (mismatches),
        .pending      (pending),
        .inserts_ok   (inserts_ok),
        .inserts_full (inserts_full),
        .reads_ok     (reads_ok),
        .reads_range  (reads_range)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("timeout after %0d cycles with no word moving", stall_cycles);
            $display("end of test: mismatches");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    task automatic send_word(input logic k, input logic [DATA_W-1:0] v,
                             input logic [POS_W-1:0] p);
        int gap_pct;
        gap_pct = (idle_mode == IDLE_HEAVY) ? 72 : (idle_mode == IDLE_LIGHT) ? 6 : 0;
        while (int'($urandom_range(0, 99)) < gap_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start    <= 1'b1;
        kind     <= k;
        value    <= v;
        position <= p;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
        if (k == KIND_INSERT && fill < CAPACITY)
            fill++;
    endtask

    task automatic hold_until_drained();
        start <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    // favor short walks, with some near the tail and some anywhere
    function automatic logic [POS_W-1:0] pick_position();
        int roll;
        int lo;
        int hi;
        roll = $urandom_range(0, 9);
        lo   = (fill > 1) ? fill - 1 : 0;
        hi   = (fill + 1 > CAPACITY) ? CAPACITY : fill + 1;
        if (roll < 5)
            return POS_W'($urandom_range(0, 7));
        if (roll < 7)
            return POS_W'($urandom_range(lo, hi));
        if (roll < 9)
            return POS_W'($urandom_range(0, CAPACITY));
        return $urandom_range(0, 1) ? POS_W'(CAPACITY) : '0;
    endfunction

    initial
    begin
        int          roll;
        logic [31:0] v;
        clk          = 1'b0;
        rst_n        = 1'b0;
        start        = 1'b0;
        kind         = KIND_INSERT;
        value        = '0;
        position     = '0;
        fill         = 0;
        stall_cycles = 0;
        idle_mode    = IDLE_NONE;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty list: reads out of range, insert lands at head whatever the position
        send_word(KIND_READ,   32'h0000_0000, 9'd0);
        send_word(KIND_READ,   32'hFFFF_FFFF, 9'd256);
        send_word(KIND_INSERT, 32'h0000_0000, 9'd5);
        send_word(KIND_READ,   32'h0000_0000, 9'd0);
        send_word(KIND_INSERT, 32'hFFFF_FFFF, 9'd0);
        send_word(KIND_INSERT, 32'hA5A5_A5A5, 9'd256);
        send_word(KIND_INSERT, 32'h1234_5678, 9'd1);
        send_word(KIND_INSERT, 32'h8000_0000, 9'd2);
        send_word(KIND_INSERT, 32'h5A5A_5A5A, 9'd5);
        for (int i = 0; i <= 5; i++)
            send_word(KIND_READ, 32'h0000_0000, 9'(i));
        send_word(KIND_READ,   32'h0000_0000, 9'd256);
        send_word(KIND_INSERT, 32'h7FFF_FFFF, 9'd0);
        send_word(KIND_READ,   32'h0000_0000, 9'd5);
        send_word(KIND_INSERT, 32'h0000_0001, 9'd256);
        send_word(KIND_READ,   32'h0000_0000, 9'd7);
        send_word(KIND_READ,   32'h0000_0000, 9'd6);
        hold_until_drained();

        for (int ph = 0; ph < ITEMS / PHASE_ITEMS; ph++)
        begin
            idle_mode = idle_mode_t'(ph % 3);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                roll = $urandom_range(0, 9);
                v = (roll == 0) ? 32'h0000_0000 : (roll == 1) ? 32'hFFFF_FFFF : $urandom();
                if ($urandom_range(0, 99) < 55)
                    send_word(KIND_INSERT, v, pick_position());
                else
                    send_word(KIND_READ, v, pick_position());
            end
            hold_until_drained();
        end

        repeat (DRAIN_CYCLES) @(negedge clk);
        $display("covered %0d inserts placed, %0d refused on a full store, %0d reads, %0d past the end",
                 inserts_ok, inserts_full, reads_ok, reads_range);
        $display("sender phases: steady, gaps in most cycles, rare gaps; store filled to %0d slots",
                 fill);
        if (mismatches == 0 && pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
